// ----- src/twcr_pkg.sv -----
package twcr_pkg;

  // Build defaults and fixed limits
  localparam int TEX_DIM_MAX_DEF = 128;
  localparam int MAX_ROWS        = 1024;
  localparam int MAX_COLS        = 2048;
  localparam int BYTES_PER_PIXEL = 4;

  // Q16.16 position and step
  localparam int FRAC_BITS = 16;
  localparam int POS_W     = 32;

  // Field widths
  localparam int CMD_W     = 2;
  localparam int TEXIDX_W  = 14;
  localparam int TEXEL_W   = 32;
  localparam int COL_W     = 11;
  localparam int DSTART_W  = 10;
  localparam int DEND_W    = 11;
  localparam int LH_W      = 16;
  localparam int FRAC_W    = 16;
  localparam int ROW_W     = 10;
  localparam int POFF_W    = 24;
  localparam int ROWCNT_W  = 11;
  localparam int SH_W      = 11;
  localparam int LB_W      = 15;
  localparam int DIM_CFG_W = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING_COLOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_COLOR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SOUTH_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SOUTH_HEIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NORTH_WIDTH   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NORTH_HEIGHT  = 3'd7;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd2;

  // Stream payloads, last declared field in the lowest bits
  typedef struct packed {
    logic [6:0]          pad;
    logic                ray_y_negative;
    logic                ray_x_positive;
    logic                side;
    logic [FRAC_W-1:0]   wall_frac;
    logic [LH_W-1:0]     line_height;
    logic [DEND_W-1:0]   draw_end;
    logic [DSTART_W-1:0] draw_start;
    logic [COL_W-1:0]    column;
    logic [TEXEL_W-1:0]  texel_value;
    logic [TEXIDX_W-1:0] texel_index;
  } twcr_in_data_t;

  typedef struct packed {
    logic             tex_select;
    logic [CMD_W-1:0] command;
  } twcr_in_user_t;

  typedef struct packed {
    logic [5:0]         pad;
    logic [TEXEL_W-1:0] color;
    logic [POFF_W-1:0]  pixel_offset;
    logic [ROW_W-1:0]   row;
  } twcr_out_data_t;

  localparam int IN_TDATA_W  = $bits(twcr_in_data_t);
  localparam int IN_TUSER_W  = $bits(twcr_in_user_t);
  localparam int OUT_TDATA_W = $bits(twcr_out_data_t);

  // Controller to datapath
  typedef struct packed {
    logic tex_we;
    logic start;
    logic emit;
    logic div_step;
    logic pos_init;
    logic out_load;
  } twcr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_row;
  } twcr_stat_t;

  // Quotient bits of the step divider: texture height shifted up by the fraction
  function automatic int div_steps(input int tex_dim_max);
    div_steps = FRAC_BITS + $clog2(tex_dim_max + 1);
  endfunction

endpackage

// ----- src/textured_wall_column_renderer.sv -----
// Pixel item: its result passes the registered texture read and pixel stage, then the output
// register; pixel items stream at one per cycle while results are taken.
// Load item: written to the texture store as accepted. Column start: the input stays closed
// while the bit-serial step divider runs (one quotient bit per cycle) and then the multiply.
// Reset: rst_n is synchronous and active low; it idles the controller, drops pending pixels
// and restores the register defaults. The texture store is not cleared.
module textured_wall_column_renderer
  import twcr_pkg::*;
#(
  parameter int TEX_DIM_MAX = TEX_DIM_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // texel_index, texel_value, column, draw_start, draw_end, line_height, wall_frac,
  // side, ray_x_positive, ray_y_negative, zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // command, tex_select
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // row, pixel_offset, color, zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  twcr_in_data_t  in_d;
  twcr_in_user_t  in_u;
  twcr_out_data_t out_d;
  twcr_cmd_t      cmd;
  twcr_stat_t     stat;

  assign in_d      = in_tdata;
  assign in_u      = in_tuser;
  assign out_tdata = out_d;

  twcr_ctrl #(
    .TEX_DIM_MAX (TEX_DIM_MAX)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_command (in_u.command),
    .out_tready (out_tready),
    .stat       (stat),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  twcr_datapath #(
    .TEX_DIM_MAX (TEX_DIM_MAX)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_d          (in_d),
    .in_tex_select (in_u.tex_select),
    .cmd           (cmd),
    .stat          (stat),
    .out_d         (out_d),
    .out_last      (out_tlast)
  );

endmodule

// ----- src/twcr_tex_ram.sv -----
module twcr_tex_ram
  import twcr_pkg::*;
#(
  parameter int DEPTH  = 2 * TEX_DIM_MAX_DEF * TEX_DIM_MAX_DEF,
  parameter int DATA_W = TEXEL_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, held when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/twcr_datapath.sv -----
module twcr_datapath
  import twcr_pkg::*;
#(
  parameter int TEX_DIM_MAX = TEX_DIM_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  twcr_in_data_t         in_d,
  input  logic                  in_tex_select,
  input  twcr_cmd_t             cmd,
  output twcr_stat_t            stat,
  output twcr_out_data_t        out_d,
  output logic                  out_last
);

  localparam int DIM_W     = $clog2(TEX_DIM_MAX + 1);
  localparam int TX_W      = $clog2(TEX_DIM_MAX);
  localparam int TEX_WORDS = TEX_DIM_MAX * TEX_DIM_MAX;
  localparam int IDX_W     = $clog2(TEX_WORDS);
  localparam int ADDR_W    = $clog2(2 * TEX_WORDS);
  localparam int IDXF_W    = DIM_W + TX_W;
  localparam int IDXC_W    = (TEXIDX_W > $clog2(TEX_WORDS + 1)) ? TEXIDX_W
                                                                : $clog2(TEX_WORDS + 1);
  localparam int DCMP_W    = (DIM_W > DIM_CFG_W) ? DIM_W : DIM_CFG_W;
  localparam int DIV_W     = div_steps(TEX_DIM_MAX);
  localparam int OFFS_W    = 18;
  localparam int PROD_W    = OFFS_W + DIV_W + 1;
  localparam int COLM_W    = $clog2(MAX_COLS);
  localparam int POFF_F_W  = ROWCNT_W + LB_W;

  // Clamp a texture dimension to 1..TEX_DIM_MAX
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] v);
    logic [DCMP_W-1:0] vx;
    vx = DCMP_W'(v);
    if (vx == '0) begin
      clamp_dim = DIM_W'(1);
    end else if (vx > DCMP_W'(TEX_DIM_MAX)) begin
      clamp_dim = DIM_W'(TEX_DIM_MAX);
    end else begin
      clamp_dim = DIM_W'(vx);
    end
  endfunction

  // Configuration registers
  logic [SH_W-1:0]      scr_h_r;
  logic [TEXEL_W-1:0]   ceil_color_r;
  logic [TEXEL_W-1:0]   floor_color_r;
  logic [LB_W-1:0]      line_bytes_r;
  logic [DIM_CFG_W-1:0] s_width_r;
  logic [DIM_CFG_W-1:0] s_height_r;
  logic [DIM_CFG_W-1:0] n_width_r;
  logic [DIM_CFG_W-1:0] n_height_r;

  // Column state
  logic [COL_W-1:0]    col_r;
  logic [DSTART_W-1:0] span_start_r;
  logic [DEND_W-1:0]   span_end_r;
  logic                lat_tex_r;
  logic [TX_W-1:0]     tex_col_r;
  logic [ROWCNT_W-1:0] row_r;
  logic [POS_W-1:0]    pos_r;
  logic [DIV_W-1:0]    step_r;

  // Step divider and start offset
  logic signed [OFFS_W-1:0] off_r;
  logic [DIV_W-1:0]         quo_r;
  logic [LH_W-1:0]          rem_r;
  logic [LH_W-1:0]          dvsr_r;

  // Pixel stage and output register
  logic [ROW_W-1:0]   s1_row_r;
  logic [POFF_W-1:0]  s1_poff_r;
  logic [TEXEL_W-1:0] s1_color_r;
  logic               s1_use_tex_r;
  logic               s1_last_r;
  logic [ROW_W-1:0]   out_row_r;
  logic [POFF_W-1:0]  out_poff_r;
  logic [TEXEL_W-1:0] out_color_r;
  logic               out_last_r;

  // Combinational values
  logic [SH_W-1:0]            sh;
  logic [DIM_W-1:0]           sel_w;
  logic [DIM_W-1:0]           sel_h;
  logic [LH_W-1:0]            lh;
  logic [FRAC_W+DIM_W-1:0]    frac_prod;
  logic [DIM_W-1:0]           tx_raw;
  logic [DIM_W-1:0]           tx_fin;
  logic                       mirror;
  logic [LH_W:0]              rem_sh;
  logic                       rem_ge;
  logic signed [PROD_W-1:0]   prod;
  logic [PROD_W-POS_W:0]      prod_top;
  logic [POS_W-1:0]           pos_sat;
  logic [DIM_W-1:0]           tw;
  logic [DIM_W-1:0]           th;
  logic [FRAC_W-1:0]          ty_raw;
  logic [TX_W-1:0]            ty;
  logic [TX_W-1:0]            tx;
  logic [IDXF_W-1:0]          idx_full;
  logic                       is_floor;
  logic                       is_ceil;
  logic                       is_tex;
  logic [POS_W:0]             pos_sum;
  logic [POS_W-1:0]           pos_next;
  logic                       last;
  logic [POFF_F_W-1:0]        poff_full;
  logic                       load_ok;
  logic [ADDR_W-1:0]          waddr;
  logic [ADDR_W-1:0]          raddr;
  logic [TEXEL_W-1:0]         mem_q;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_h_r       <= SH_W'(480);
      ceil_color_r  <= '0;
      floor_color_r <= '0;
      line_bytes_r  <= LB_W'(4096);
      s_width_r     <= DIM_CFG_W'(64);
      s_height_r    <= DIM_CFG_W'(64);
      n_width_r     <= DIM_CFG_W'(64);
      n_height_r    <= DIM_CFG_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_HEIGHT: scr_h_r       <= cfg_wdata[SH_W-1:0];
        REG_CEILING_COLOR: ceil_color_r  <= cfg_wdata[TEXEL_W-1:0];
        REG_FLOOR_COLOR:   floor_color_r <= cfg_wdata[TEXEL_W-1:0];
        REG_LINE_BYTES:    line_bytes_r  <= cfg_wdata[LB_W-1:0];
        REG_SOUTH_WIDTH:   s_width_r     <= cfg_wdata[DIM_CFG_W-1:0];
        REG_SOUTH_HEIGHT:  s_height_r    <= cfg_wdata[DIM_CFG_W-1:0];
        REG_NORTH_WIDTH:   n_width_r     <= cfg_wdata[DIM_CFG_W-1:0];
        REG_NORTH_HEIGHT:  n_height_r    <= cfg_wdata[DIM_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Column start: texture column, offset and divider seed
  always_comb begin
    if (scr_h_r == '0) begin
      sh = SH_W'(1);
    end else if (scr_h_r > SH_W'(MAX_ROWS)) begin
      sh = SH_W'(MAX_ROWS);
    end else begin
      sh = scr_h_r;
    end
    sel_w     = clamp_dim(in_tex_select ? n_width_r : s_width_r);
    sel_h     = clamp_dim(in_tex_select ? n_height_r : s_height_r);
    lh        = (in_d.line_height == '0) ? LH_W'(1) : in_d.line_height;
    frac_prod = in_d.wall_frac * sel_w;
    tx_raw    = frac_prod[FRAC_W+DIM_W-1:FRAC_W];
    mirror    = (!in_d.side && in_d.ray_x_positive) || (in_d.side && in_d.ray_y_negative);
    tx_fin    = mirror ? (sel_w - tx_raw - DIM_W'(1)) : tx_raw;
  end

  // One restoring step of the divider
  always_comb begin
    rem_sh = {rem_r, quo_r[DIV_W-1]};
    rem_ge = (rem_sh >= {1'b0, dvsr_r});
  end

  // Start position: offset times step, saturated to signed 32 bits
  always_comb begin
    prod     = off_r * $signed({1'b0, quo_r});
    prod_top = prod[PROD_W-1:POS_W-1];
    if ((&prod_top) || !(|prod_top)) begin
      pos_sat = prod[POS_W-1:0];
    end else if (prod[PROD_W-1]) begin
      pos_sat = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      pos_sat = {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  // Pixel tick: color source, texel address, next position
  always_comb begin
    tw       = clamp_dim(lat_tex_r ? n_width_r : s_width_r);
    th       = clamp_dim(lat_tex_r ? n_height_r : s_height_r);
    ty_raw   = pos_r[POS_W-1] ? '0 : pos_r[POS_W-1:FRAC_BITS];
    ty       = (ty_raw >= FRAC_W'(th)) ? TX_W'(th - DIM_W'(1)) : TX_W'(ty_raw);
    tx       = (DIM_W'(tex_col_r) >= tw) ? TX_W'(tw - DIM_W'(1)) : tex_col_r;
    // Index stays below width times height, so no wrap is needed
    idx_full = tw * ty + IDXF_W'(tx);
    raddr    = lat_tex_r ? (ADDR_W'(idx_full[IDX_W-1:0]) + ADDR_W'(TEX_WORDS))
                         : ADDR_W'(idx_full[IDX_W-1:0]);
    is_floor = (row_r >= span_end_r);
    is_ceil  = (row_r < ROWCNT_W'(span_start_r));
    is_tex   = !is_floor && !is_ceil;
    pos_sum  = {pos_r[POS_W-1], pos_r} + (POS_W+1)'(step_r);
    pos_next = (pos_sum[POS_W:POS_W-1] == 2'b01) ? {1'b0, {(POS_W-1){1'b1}}}
                                                 : pos_sum[POS_W-1:0];
    last     = (({1'b0, row_r} + (ROWCNT_W+1)'(1)) >= (ROWCNT_W+1)'(sh));
    poff_full = row_r * line_bytes_r + POFF_F_W'(col_r) * POFF_F_W'(BYTES_PER_PIXEL);
  end

  // Texel load address
  always_comb begin
    load_ok = (IDXC_W'(in_d.texel_index) < IDXC_W'(TEX_WORDS));
    waddr   = in_tex_select ? (ADDR_W'(IDX_W'(in_d.texel_index)) + ADDR_W'(TEX_WORDS))
                            : ADDR_W'(IDX_W'(in_d.texel_index));
  end

  twcr_tex_ram #(
    .DEPTH  (2 * TEX_WORDS),
    .DATA_W (TEXEL_W)
  ) u_tex_ram (
    .clk   (clk),
    .we    (cmd.tex_we && load_ok),
    .waddr (waddr),
    .wdata (in_d.texel_value),
    .re    (cmd.emit && is_tex),
    .raddr (raddr),
    .rdata (mem_q)
  );

  // Latch the column and run the divider
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      col_r        <= COL_W'(in_d.column[COLM_W-1:0]);
      span_start_r <= in_d.draw_start;
      span_end_r   <= in_d.draw_end;
      lat_tex_r    <= in_tex_select;
      tex_col_r    <= tx_fin[TX_W-1:0];
      off_r        <= $signed(OFFS_W'(in_d.draw_start) + OFFS_W'(lh[LH_W-1:1])
                              - OFFS_W'(sh[SH_W-1:1]));
      quo_r        <= {sel_h, {FRAC_BITS{1'b0}}};
      rem_r        <= '0;
      dvsr_r       <= lh;
    end else if (cmd.div_step) begin
      rem_r <= LH_W'(rem_ge ? (rem_sh - {1'b0, dvsr_r}) : rem_sh);
      quo_r <= {quo_r[DIV_W-2:0], rem_ge};
    end
  end

  // Row counter and texture position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else if (cmd.start) begin
      row_r <= '0;
    end else if (cmd.emit && !last) begin
      row_r <= row_r + ROWCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pos_init) begin
      step_r <= quo_r;
      pos_r  <= pos_sat;
    end else if (cmd.emit && is_tex) begin
      pos_r <= pos_next;
    end
  end

  // Capture the pixel while its texel is read
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      s1_row_r     <= row_r[ROW_W-1:0];
      s1_poff_r    <= poff_full[POFF_W-1:0];
      s1_color_r   <= is_floor ? floor_color_r : ceil_color_r;
      s1_use_tex_r <= is_tex;
      s1_last_r    <= last;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row_r   <= s1_row_r;
      out_poff_r  <= s1_poff_r;
      out_color_r <= s1_use_tex_r ? mem_q : s1_color_r;
      out_last_r  <= s1_last_r;
    end
  end

  assign stat.last_row     = last;
  assign out_d.pad         = '0;
  assign out_d.color       = out_color_r;
  assign out_d.pixel_offset = out_poff_r;
  assign out_d.row         = out_row_r;
  assign out_last          = out_last_r;

endmodule

// ----- src/twcr_ctrl.sv -----
module twcr_ctrl
  import twcr_pkg::*;
#(
  parameter int TEX_DIM_MAX = TEX_DIM_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic [CMD_W-1:0] in_command,
  input  logic             out_tready,
  input  twcr_stat_t       stat,
  output logic             in_tready,
  output logic             out_tvalid,
  output twcr_cmd_t        cmd
);

  localparam int DIV_STEPS = div_steps(TEX_DIM_MAX);
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             active_r, active_nxt;
  logic             s1_v_r, s1_v_nxt;
  logic             o_v_r, o_v_nxt;
  logic             s1_adv;
  logic             fire;

  // Handshake and datapath commands; hold the input closed during reset
  always_comb begin
    s1_adv       = s1_v_r && (!o_v_r || out_tready);
    in_tready    = rst_n && (state_r == ST_IDLE) && (!s1_v_r || s1_adv);
    fire         = in_tvalid && in_tready;
    cmd.tex_we   = fire && (in_command == CMD_LOAD);
    cmd.start    = fire && (in_command == CMD_START);
    cmd.emit     = fire && (in_command == CMD_PIXEL) && active_r;
    cmd.div_step = (state_r == ST_DIV);
    cmd.pos_init = (state_r == ST_MUL);
    cmd.out_load = s1_adv;
  end

  // Sequence a column start through divide and multiply
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    active_nxt = active_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.start) begin
          state_nxt = ST_DIV;
          cnt_nxt   = '0;
        end
      end
      ST_DIV: begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_MUL;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_MUL: begin
        state_nxt  = ST_IDLE;
        active_nxt = 1'b1;
      end
      default: state_nxt = ST_IDLE;
    endcase
    // Drop out of the column after its final row
    if (cmd.emit && stat.last_row) begin
      active_nxt = 1'b0;
    end
  end

  // Advance the pixel stage and the output register
  always_comb begin
    s1_v_nxt = cmd.emit ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
    o_v_nxt  = s1_adv ? 1'b1 : (out_tready ? 1'b0 : o_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      active_r <= 1'b0;
      s1_v_r   <= 1'b0;
      o_v_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      active_r <= active_nxt;
      s1_v_r   <= s1_v_nxt;
      o_v_r    <= o_v_nxt;
    end
  end

  assign out_tvalid = o_v_r;

endmodule

// ----- src/twcr_checker.sv -----
module twcr_checker
  import twcr_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TUSER_W-1:0]  in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  logic in_fire;
  assign in_fire = in_tvalid && in_tready;

  // A stalled result holds its item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Column start keeps the input closed while the step is divided
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_tuser[CMD_W-1:0] == CMD_START) |=> !in_tready)
    else $error("input open during column start");

  // A fresh result comes from a pixel item, through the pixel stage and the output register
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_fire && (in_tuser[CMD_W-1:0] == CMD_PIXEL), 2))
    else $error("result without a pixel item");

endmodule

bind textured_wall_column_renderer twcr_checker u_twcr_checker (.*);

// ----- verif/tb_textured_wall_column_renderer.sv -----
`timescale 1ns / 100ps

import twcr_pkg::*;

localparam int     TEX_WORDS = TEX_DIM_MAX_DEF * TEX_DIM_MAX_DEF;
localparam longint POS_MAX   = 64'sd2147483647;
localparam longint POS_MIN   = -64'sd2147483648;

typedef struct packed {
  logic [ROW_W-1:0]   row;
  logic [POFF_W-1:0]  offset;
  logic [TEXEL_W-1:0] color;
  logic               last;
} pixel_exp_t;

// Column predictor plus the queue of pixels it still owes
class column_scoreboard;
  bit [TEXEL_W-1:0]    texels [2*TEX_WORDS];
  logic [SH_W-1:0]     screen_height = 480;
  logic [TEXEL_W-1:0]  ceiling_color = '0;
  logic [TEXEL_W-1:0]  floor_color   = '0;
  logic [LB_W-1:0]     line_bytes    = 4096;
  logic [DIM_CFG_W-1:0] south_w = 64, south_h = 64, north_w = 64, north_h = 64;

  int unsigned row_cnt, tex_step, tex_col, col_l, span_start, span_end;
  int          tex_pos;
  bit          tex_l, active;
  pixel_exp_t  pending_q [$];
  int          errors;

  function int unsigned dim_of(bit sel, bit vertical);
    logic [DIM_CFG_W-1:0] v;
    v = sel ? (vertical ? north_h : north_w) : (vertical ? south_h : south_w);
    if (v == 0) return 1;
    if (v > TEX_DIM_MAX_DEF) return TEX_DIM_MAX_DEF;
    return v;
  endfunction

  function int unsigned rows_on_screen();
    if (screen_height == 0) return 1;
    if (screen_height > MAX_ROWS) return MAX_ROWS;
    return screen_height;
  endfunction

  function int saturate(longint v);
    if (v > POS_MAX) return int'(POS_MAX);
    if (v < POS_MIN) return int'(POS_MIN);
    return int'(v);
  endfunction

  function int pending();
    return pending_q.size();
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_SCREEN_HEIGHT: screen_height = v[SH_W-1:0];
      REG_CEILING_COLOR: ceiling_color = v;
      REG_FLOOR_COLOR:   floor_color   = v;
      REG_LINE_BYTES:    line_bytes    = v[LB_W-1:0];
      REG_SOUTH_WIDTH:   south_w       = v[DIM_CFG_W-1:0];
      REG_SOUTH_HEIGHT:  south_h       = v[DIM_CFG_W-1:0];
      REG_NORTH_WIDTH:   north_w       = v[DIM_CFG_W-1:0];
      REG_NORTH_HEIGHT:  north_h       = v[DIM_CFG_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the column state for one accepted item
  function void note_item(twcr_in_user_t u, twcr_in_data_t d);
    int unsigned w, h, lh, r, ty, tx, idx;
    longint      off;
    pixel_exp_t  e;
    case (u.command)
      CMD_LOAD: texels[{u.tex_select, d.texel_index}] = d.texel_value;
      CMD_START: begin
        w  = dim_of(u.tex_select, 1'b0);
        h  = dim_of(u.tex_select, 1'b1);
        lh = (d.line_height == 0) ? 1 : d.line_height;
        col_l      = d.column;
        span_start = d.draw_start;
        span_end   = d.draw_end;
        tex_l      = u.tex_select;
        tx = 32'((longint'(d.wall_frac) * longint'(w)) >> 16);
        // mirror so textures are not flipped on the far faces
        if ((!d.side && d.ray_x_positive) || (d.side && d.ray_y_negative))
          tx = w - tx - 1;
        tex_col  = tx;
        tex_step = (h << FRAC_BITS) / lh;
        off = longint'(span_start) - longint'(rows_on_screen() / 2) + longint'(lh / 2);
        tex_pos = saturate(off * longint'(tex_step));
        row_cnt = 0;
        active  = 1'b1;
      end
      CMD_PIXEL: if (active) begin
        r = row_cnt;
        if (r >= span_end) begin
          e.color = floor_color;
        end else if (r < span_start) begin
          e.color = ceiling_color;
        end else begin
          w  = dim_of(tex_l, 1'b0);
          h  = dim_of(tex_l, 1'b1);
          ty = (tex_pos < 0) ? 0 : (tex_pos >> FRAC_BITS);
          if (ty >= h) ty = h - 1;
          tx = tex_col;
          if (tx >= w) tx = w - 1;
          idx = (w * ty + tx) % TEX_WORDS;
          e.color = texels[tex_l * TEX_WORDS + idx];
          tex_pos = saturate(longint'(tex_pos) + longint'(tex_step));
        end
        off = longint'(r) * longint'(line_bytes) + longint'(col_l) * BYTES_PER_PIXEL;
        e.row    = r[ROW_W-1:0];
        e.offset = off[POFF_W-1:0];
        e.last   = (r + 1 >= rows_on_screen());
        pending_q.push_back(e);
        if (e.last) active = 1'b0;
        else row_cnt = (r + 1) & 32'h7FF;
      end
      default: ;
    endcase
  endfunction

  task report_mismatch(string msg);
    errors++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  // Compare one accepted pixel with the oldest one owed
  task check_result(twcr_out_data_t d, logic last);
    pixel_exp_t e;
    if (pending_q.size() == 0) begin
      report_mismatch($sformatf("pixel with none owed: row %0d color %h", d.row, d.color));
      return;
    end
    e = pending_q.pop_front();
    if (d.row !== e.row)
      report_mismatch($sformatf("row %0d, want %0d", d.row, e.row));
    if (d.pixel_offset !== e.offset)
      report_mismatch($sformatf("row %0d offset %h, want %h", e.row, d.pixel_offset, e.offset));
    if (d.color !== e.color)
      report_mismatch($sformatf("row %0d color %h, want %h", e.row, d.color, e.color));
    if (last !== e.last)
      report_mismatch($sformatf("row %0d last %b, want %b", e.row, last, e.last));
  endtask
endclass

module tb_textured_wall_column_renderer;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  twcr_in_data_t         in_data    = '0;
  twcr_in_user_t         in_user    = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  twcr_out_data_t        out_data;
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  column_scoreboard sb = new();
  bit               loaded [2*TEX_WORDS];
  int               burst_left = 0;
  int unsigned      cycles = 0;

  textured_wall_column_renderer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_data),
    .in_tuser   (in_user),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_data),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_textured_wall_column_renderer: done, errors");
      $finish;
    end
  end

  // Check every pixel taken from the block
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_data, out_tlast);
  end

  // Receiver: ready stretches, random stalls, and long hold-offs that back up the block
  initial begin : receiver
    int  mode;
    bit  held;
    held = 1'b0;
    forever begin
      mode = $urandom_range(0, 39);
      if ((!held && sb.pending() >= 2) || mode == 0) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat ($urandom_range(150, 300)) @(posedge clk);
      end else begin
        repeat ($urandom_range(5, 60)) begin
          out_tready <= (mode < 16) ? 1'b1 : ($urandom_range(0, mode / 8) == 0);
          @(posedge clk);
        end
      end
    end
  end

  function automatic twcr_in_data_t random_fields();
    twcr_in_data_t d;
    d = '0;
    d.texel_index    = TEXIDX_W'($urandom);
    d.texel_value    = $urandom;
    d.column         = COL_W'($urandom);
    d.draw_start     = DSTART_W'($urandom);
    d.draw_end       = DEND_W'($urandom_range(0, 1024));
    d.line_height    = LH_W'($urandom);
    d.wall_frac      = FRAC_W'($urandom);
    d.side           = 1'($urandom);
    d.ray_x_positive = 1'($urandom);
    d.ray_y_negative = 1'($urandom);
    return d;
  endfunction

  // Offer one item in bursts with random gaps; note it once accepted
  task automatic send(input logic [CMD_W-1:0] cmd, input bit sel, input twcr_in_data_t d);
    int            gap;
    twcr_in_user_t u;
    u.command    = cmd;
    u.tex_select = sel;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_data   <= d;
    in_user   <= u;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    if (cmd == CMD_LOAD) loaded[{sel, d.texel_index}] = 1'b1;
    sb.note_item(u, d);
  endtask

  // Loads to random places and unused command codes
  task automatic send_noise();
    send($urandom_range(0, 1) ? CMD_LOAD : CMD_UNUSED, 1'($urandom), random_fields());
  endtask

  // Stop offering and let the block finish everything in flight
  task automatic drain();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Write all registers while idle, then load every texel the new sizes can reach
  task automatic configure(input int unsigned rows, input int unsigned ceil_c,
                           input int unsigned floor_c, input int unsigned lbytes,
                           input int unsigned sw, input int unsigned sh,
                           input int unsigned nw, input int unsigned nh);
    twcr_in_data_t d;
    int unsigned   area;
    drain();
    set_reg(REG_SCREEN_HEIGHT, rows);
    set_reg(REG_CEILING_COLOR, ceil_c);
    set_reg(REG_FLOOR_COLOR, floor_c);
    set_reg(REG_LINE_BYTES, lbytes);
    set_reg(REG_SOUTH_WIDTH, sw);
    set_reg(REG_SOUTH_HEIGHT, sh);
    set_reg(REG_NORTH_WIDTH, nw);
    set_reg(REG_NORTH_HEIGHT, nh);
    for (int s = 0; s < 2; s++) begin
      area = sb.dim_of(s[0], 1'b0) * sb.dim_of(s[0], 1'b1);
      for (int i = 0; i < area; i++) begin
        if (!loaded[s * TEX_WORDS + i]) begin
          d = random_fields();
          d.texel_index = TEXIDX_W'(i);
          send(CMD_LOAD, s[0], d);
        end
      end
    end
  endtask

  // Start a column and tick through it, with optional noise between ticks
  task automatic draw_column(input bit sel, input twcr_in_data_t d, input int ticks,
                             input int noise_pct);
    send(CMD_START, sel, d);
    repeat (ticks) begin
      if ($urandom_range(0, 99) < noise_pct) send_noise();
      send(CMD_PIXEL, 1'($urandom), random_fields());
    end
  endtask

  // Mostly whole columns with random geometry, some stray items
  task automatic random_phase(input int budget);
    twcr_in_data_t d;
    int            rows, ticks, done;
    rows = sb.rows_on_screen();
    done = 0;
    // tick any column left over from the previous setting under the new one
    repeat ($urandom_range(0, 3)) send(CMD_PIXEL, 1'($urandom), random_fields());
    while (done < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1)) send(CMD_PIXEL, 1'($urandom), random_fields());
        else send_noise();
        done++;
      end else begin
        d = random_fields();
        if ($urandom_range(0, 3) != 0) begin
          d.draw_start = DSTART_W'($urandom_range(0, rows + 2));
          d.draw_end   = DEND_W'($urandom_range(0, rows + 3));
        end else begin
          d.draw_end = DEND_W'($urandom);
        end
        if ($urandom_range(0, 1)) d.line_height = LH_W'($urandom_range(0, 2 * rows + 4));
        ticks = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(0, rows + 2);
        draw_column(1'($urandom), d, ticks, 5);
        done += ticks + 1;
      end
    end
  endtask

  initial begin : stimulus
    twcr_in_data_t d;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: small screen, small textures
    configure(12, 32'h0000_0000, 32'hFFFF_FFFF, 4, 5, 4, 3, 2);
    send(CMD_PIXEL, 1'b0, random_fields());
    send(CMD_UNUSED, 1'b1, random_fields());
    d = random_fields();
    d.texel_index = '1;
    d.texel_value = '1;
    send(CMD_LOAD, 1'b1, d);
    d.texel_index = '0;
    d.texel_value = '0;
    send(CMD_LOAD, 1'b0, d);

    // zero line height, mirrored x face, last column, start position negative
    d = random_fields();
    d.column = '1;
    d.draw_start = 3;
    d.draw_end = 9;
    d.line_height = 0;
    d.wall_frac = '1;
    d.side = 1'b0;
    d.ray_x_positive = 1'b1;
    d.ray_y_negative = 1'b0;
    draw_column(1'b0, d, 4, 0);

    // restart while active: tall wall past the screen, mirrored y face, one tick past the end
    d = random_fields();
    d.column = '0;
    d.draw_start = 0;
    d.draw_end = 1024;
    d.line_height = '1;
    d.wall_frac = '0;
    d.side = 1'b1;
    d.ray_y_negative = 1'b1;
    draw_column(1'b1, d, 13, 0);

    // inverted span, left running into the next setting
    d = random_fields();
    d.draw_start = '1;
    d.draw_end = 0;
    d.line_height = 1;
    d.wall_frac = 16'h8000;
    d.side = 1'b1;
    d.ray_y_negative = 1'b0;
    draw_column(1'b0, d, 4, 0);

    // Full screen height, widest rows: offsets wrap, position saturates at both ends
    configure(2047, $urandom, $urandom, 32767, 1, 255, 2, 2);
    repeat (3) send(CMD_PIXEL, 1'($urandom), random_fields());
    d = random_fields();
    d.draw_start = 0;
    d.draw_end = 1024;
    d.line_height = 1;
    draw_column(1'b0, d, 530, 2);

    // Random settings, one with each texture at the largest size in one dimension, smallest in the other
    for (int p = 0; p < 8; p++) begin
      if (p == 3)
        configure(33, $urandom, $urandom, $urandom_range(0, 32767), 255, 0, 0, 255);
      else
        configure($urandom_range(0, 40), $urandom, $urandom, $urandom_range(0, 32767),
                  $urandom_range(0, 12), $urandom_range(0, 12),
                  $urandom_range(0, 12), $urandom_range(0, 12));
      random_phase(12);
    end

    drain();
    if (sb.errors == 0) begin
      $display("tb_textured_wall_column_renderer: done, clean");
    end else begin
      $display("tb_textured_wall_column_renderer: done, errors");
    end
    $finish;
  end
endmodule

// ----- textured_wall_column_renderer.f -----
src/twcr_pkg.sv
src/twcr_tex_ram.sv
src/twcr_datapath.sv
src/twcr_ctrl.sv
src/textured_wall_column_renderer.sv
src/twcr_checker.sv
verif/tb_textured_wall_column_renderer.sv
